// ----- sv/cadt_pkg.sv -----
// ----------------------------------------------------------------------------
// cadt_pkg
// Types, codes and check functions shared by the call ack deadline tracker.
// ----------------------------------------------------------------------------
package cadt_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned GEN_W      = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned MID_W      = 40;

  localparam logic [TMO_W-1:0] ACK_TIMEOUT_RESET = 32'd1000;

  // register select: bit 3 of paddr picks the 8-byte slot
  localparam logic REG_LOCAL_ADDRESS  = 1'b0;
  localparam logic REG_ACK_TIMEOUT_MS = 1'b1;

  // actions
  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_BEGIN   = 2'd1;
  localparam logic [1:0] ACT_OBSERVE = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  // command kinds
  localparam logic [7:0] KIND_NONE   = 8'd0;
  localparam logic [7:0] KIND_ANSWER = 8'd1;
  localparam logic [7:0] KIND_HANGUP = 8'd2;
  localparam logic [7:0] KIND_OTHER  = 8'd3;

  // session phases
  localparam logic [1:0] SS_OTHER   = 2'd0;
  localparam logic [1:0] SS_PREVIEW = 2'd1;
  localparam logic [1:0] SS_RINGING = 2'd2;
  localparam logic [1:0] SS_TALKING = 2'd3;

  // frame constants
  localparam logic [7:0] OP_ANSWER      = 8'h03;
  localparam logic [7:0] OP_HANGUP      = 8'h02;
  localparam logic [7:0] ANSWER_TAG     = 8'h02;
  localparam logic [7:0] REPLY_FAMILY   = 8'h03;
  localparam logic [7:0] OP_HANGUP_ACK  = 8'h82;
  localparam logic [7:0] OP_ANSWER_ACK  = 8'h83;
  localparam logic [7:0] ANSWER_LEN     = 8'd7;
  localparam logic [7:0] HANGUP_LEN     = 8'd1;
  localparam logic [7:0] HANGUP_ACK_LEN = 8'd0;

  // output codes of ack_state
  localparam logic [2:0] ACK_IDLE      = 3'd0;
  localparam logic [2:0] ACK_WAITING   = 3'd1;
  localparam logic [2:0] ACK_CONFIRMED = 3'd2;
  localparam logic [2:0] ACK_EXPIRED   = 3'd3;
  localparam logic [2:0] ACK_CANCELLED = 3'd4;

  typedef enum logic [4:0] {
    TRK_IDLE      = 5'b00001,
    TRK_WAITING   = 5'b00010,
    TRK_CONFIRMED = 5'b00100,
    TRK_EXPIRED   = 5'b01000,
    TRK_CANCELLED = 5'b10000
  } track_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic [GEN_W-1:0]  sess_gen;
    logic [ADDR_W-1:0] session_peer;
    logic [1:0]        session_state;
    logic [ADDR_W-1:0] source_addr;
    logic [ADDR_W-1:0] dest_addr;
    logic [GEN_W-1:0]  command_generation;
    logic [7:0]        kind;
    logic [7:0]        opcode;
    logic [7:0]        pay_len;
    logic [55:0]       payload;
  } item_t;

  typedef struct packed {
    track_e            track;
    logic [GEN_W-1:0]  gen;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              hangup;
    logic [MID_W-1:0]  mid;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] deadline;
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] local_address;
    logic [TMO_W-1:0]  ack_timeout_ms;
  } cfg_t;

  function automatic logic [2:0] ack_code(input track_e t);
    logic [2:0] c;
    unique case (t)
      TRK_IDLE:      c = ACK_IDLE;
      TRK_WAITING:   c = ACK_WAITING;
      TRK_CONFIRMED: c = ACK_CONFIRMED;
      TRK_EXPIRED:   c = ACK_EXPIRED;
      TRK_CANCELLED: c = ACK_CANCELLED;
      default:       c = ACK_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic session_fits(
    input logic [GEN_W-1:0]  gen,
    input logic [ADDR_W-1:0] src,
    input logic [ADDR_W-1:0] dst,
    input logic              hangup,
    input logic [GEN_W-1:0]  s_gen,
    input logic [ADDR_W-1:0] s_peer,
    input logic [1:0]        s_state,
    input logic [ADDR_W-1:0] local_address
  );
    logic match;
    logic phase_ok;
    match = (gen == s_gen) && (dst == s_peer) && (src == local_address);
    if (hangup) begin
      phase_ok = (s_state == SS_PREVIEW) || (s_state == SS_RINGING) ||
                 (s_state == SS_TALKING);
    end else begin
      phase_ok = (s_state == SS_RINGING);
    end
    return match && phase_ok;
  endfunction

  function automatic logic command_ok(input item_t it);
    logic base;
    logic ans;
    logic hng;
    base = (it.kind != KIND_NONE) && (it.command_generation != '0) &&
           (it.source_addr != '0) && (it.dest_addr != '0);
    ans = (it.kind == KIND_ANSWER) && (it.opcode == OP_ANSWER) &&
          (it.pay_len == ANSWER_LEN) && (it.payload[7:0] == ANSWER_TAG) &&
          (it.payload[31:24] == 8'd0) && (it.payload[23:8] != 16'd0) &&
          (it.payload[47:32] != 16'd0) && (it.payload[55:48] != 8'd0);
    hng = (it.kind == KIND_HANGUP) && (it.opcode == OP_HANGUP) &&
          (it.pay_len == HANGUP_LEN);
    return base && (ans || hng);
  endfunction

  function automatic logic frame_ok(input item_t it, input state_t st);
    logic base;
    logic hng;
    logic ans;
    base = (it.kind == REPLY_FAMILY) && (it.source_addr == st.dst) &&
           (it.dest_addr == st.src);
    hng = (it.opcode == OP_HANGUP_ACK) && (it.pay_len == HANGUP_ACK_LEN);
    ans = (it.opcode == OP_ANSWER_ACK) && (it.pay_len == ANSWER_LEN) &&
          (it.payload[7:0] == 8'd0) && (it.payload[47:8] == st.mid) &&
          (it.payload[55:48] != 8'd0);
    return base && (st.hangup ? hng : ans);
  endfunction

endpackage

// ----- sv/cadt_step.sv -----
// ----------------------------------------------------------------------------
// cadt_step
// Next tracker state and reject flag for one item against the current state.
// ----------------------------------------------------------------------------
module cadt_step (
  input  cadt_pkg::item_t  item_i,
  input  cadt_pkg::state_t state_i,
  input  cadt_pkg::cfg_t   cfg_i,
  output cadt_pkg::state_t state_o,
  output logic             bad_o
);

  logic                          now_lt_last;
  logic                          waiting;
  logic [cadt_pkg::TIME_W:0]     sum;
  logic                          begin_hang;
  logic                          fits_new;
  logic                          fits_cur;
  logic                          cmd_good;
  logic                          frm_good;
  logic                          past_deadline;

  assign now_lt_last   = item_i.now_ms < state_i.last_time;
  assign waiting       = (state_i.track == cadt_pkg::TRK_WAITING);
  // carry out of the add flags a deadline that overflows
  assign sum           = {1'b0, item_i.now_ms} +
                         {{(cadt_pkg::TIME_W - cadt_pkg::TMO_W + 1){1'b0}}, cfg_i.ack_timeout_ms};
  assign begin_hang    = (item_i.kind == cadt_pkg::KIND_HANGUP);
  assign past_deadline = item_i.now_ms >= state_i.deadline;
  assign cmd_good      = cadt_pkg::command_ok(item_i);
  assign frm_good      = cadt_pkg::frame_ok(item_i, state_i);
  assign fits_new = cadt_pkg::session_fits(item_i.command_generation, item_i.source_addr,
                                           item_i.dest_addr, begin_hang,
                                           item_i.sess_gen, item_i.session_peer,
                                           item_i.session_state, cfg_i.local_address);
  assign fits_cur = cadt_pkg::session_fits(state_i.gen, state_i.src, state_i.dst,
                                           state_i.hangup, item_i.sess_gen,
                                           item_i.session_peer, item_i.session_state,
                                           cfg_i.local_address);

  always_comb begin
    state_o = state_i;
    bad_o   = 1'b0;
    unique case (item_i.action)
      cadt_pkg::ACT_INIT: begin
        state_o.track     = cadt_pkg::TRK_IDLE;
        state_o.gen       = '0;
        state_o.src       = '0;
        state_o.dst       = '0;
        state_o.hangup    = 1'b0;
        state_o.mid       = '0;
        state_o.deadline  = '0;
        state_o.last_time = item_i.now_ms;
      end
      cadt_pkg::ACT_BEGIN: begin
        if (waiting || !cmd_good || (cfg_i.ack_timeout_ms == '0) || now_lt_last ||
            sum[cadt_pkg::TIME_W] || !fits_new) begin
          bad_o = 1'b1;
        end else begin
          state_o.track     = cadt_pkg::TRK_WAITING;
          state_o.gen       = item_i.command_generation;
          state_o.src       = item_i.source_addr;
          state_o.dst       = item_i.dest_addr;
          state_o.hangup    = begin_hang;
          state_o.mid       = item_i.payload[47:8];
          state_o.last_time = item_i.now_ms;
          state_o.deadline  = sum[cadt_pkg::TIME_W-1:0];
        end
      end
      cadt_pkg::ACT_OBSERVE: begin
        if (!waiting || now_lt_last || past_deadline || !fits_cur || !frm_good) begin
          bad_o = 1'b1;
        end else begin
          state_o.track     = cadt_pkg::TRK_CONFIRMED;
          state_o.last_time = item_i.now_ms;
          state_o.deadline  = '0;
        end
      end
      cadt_pkg::ACT_TICK: begin
        if (now_lt_last) begin
          bad_o = 1'b1;
        end else begin
          state_o.last_time = item_i.now_ms;
          if (waiting && !fits_cur) begin
            state_o.track    = cadt_pkg::TRK_CANCELLED;
            state_o.deadline = '0;
          end else if (waiting && past_deadline) begin
            state_o.track    = cadt_pkg::TRK_EXPIRED;
            state_o.deadline = '0;
          end
        end
      end
      default: begin
        bad_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/call_ack_deadline_tracker.sv -----
// ----------------------------------------------------------------------------
// call_ack_deadline_tracker
// Follows one answer or hangup command until the peer acknowledges it.
// ----------------------------------------------------------------------------
// Usage: each input item (init, begin, observe or tick plus the session and
// frame fields) is taken on in_valid_i & in_ready_o. Every item yields exactly
// one result item (status_o, ack_state_o) on out_valid_o & out_ready_i, in
// input order.
// Path: an accepted item is held in the input register, then the check and
// state update logic feeds the result register.
// Throughput: one item per cycle while the output is not stalled; in_ready_o
// stays high while the input register or the result register is empty, or
// the result register is being drained.
// Stall: when out_ready_i is low the result holds, one more item waits in the
// input register and in_ready_o then drops until the result is taken.
// Reset: clears the tracker to idle, time and deadline to zero, the local
// address to zero and the ack timeout to 1000 ms. Configuration goes through
// the APB port: local address at 0x0, ack timeout at 0x8; pready is always high.
// ----------------------------------------------------------------------------
module call_ack_deadline_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cadt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cadt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cadt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [63:0]                       now_ms_i,
  input  logic [31:0]                       sess_gen_i,
  input  logic [47:0]                       session_peer_i,
  input  logic [1:0]                        session_state_i,
  input  logic [47:0]                       source_addr_i,
  input  logic [47:0]                       dest_addr_i,
  input  logic [31:0]                       command_generation_i,
  input  logic [7:0]                        kind_i,
  input  logic [7:0]                        opcode_i,
  input  logic [7:0]                        pay_len_i,
  input  logic [55:0]                       payload_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [2:0]                        ack_state_o
);

  cadt_pkg::cfg_t   cfg_q;
  cadt_pkg::state_t state_q;
  cadt_pkg::state_t state_d;
  cadt_pkg::item_t  item_q;
  logic             item_valid_q;
  logic             out_valid_q;
  logic             status_q;
  logic [2:0]       ack_q;
  logic             step_bad;
  logic             in_acc;
  logic             out_free;
  logic             fire;
  logic             cfg_we;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;
  assign in_acc   = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_address  <= '0;
      cfg_q.ack_timeout_ms <= cadt_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3])
        cadt_pkg::REG_LOCAL_ADDRESS:  cfg_q.local_address  <= pwdata[cadt_pkg::ADDR_W-1:0];
        cadt_pkg::REG_ACK_TIMEOUT_MS: cfg_q.ack_timeout_ms <= pwdata[cadt_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      cadt_pkg::REG_LOCAL_ADDRESS:
        prdata = {{(cadt_pkg::CFG_DATA_W - cadt_pkg::ADDR_W){1'b0}}, cfg_q.local_address};
      cadt_pkg::REG_ACK_TIMEOUT_MS:
        prdata = {{(cadt_pkg::CFG_DATA_W - cadt_pkg::TMO_W){1'b0}}, cfg_q.ack_timeout_ms};
      default: prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_acc) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action             <= action_i;
      item_q.now_ms             <= now_ms_i;
      item_q.sess_gen           <= sess_gen_i;
      item_q.session_peer       <= session_peer_i;
      item_q.session_state      <= session_state_i;
      item_q.source_addr        <= source_addr_i;
      item_q.dest_addr          <= dest_addr_i;
      item_q.command_generation <= command_generation_i;
      item_q.kind               <= kind_i;
      item_q.opcode             <= opcode_i;
      item_q.pay_len            <= pay_len_i;
      item_q.payload            <= payload_i;
    end
  end

  cadt_step u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .bad_o   (step_bad)
  );

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.track     <= cadt_pkg::TRK_IDLE;
      state_q.gen       <= '0;
      state_q.src       <= '0;
      state_q.dst       <= '0;
      state_q.hangup    <= 1'b0;
      state_q.mid       <= '0;
      state_q.last_time <= '0;
      state_q.deadline  <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= step_bad;
      ack_q    <= cadt_pkg::ack_code(state_d.track);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign ack_state_o = ack_q;

  // a deadline is armed exactly while a command is pending
  a_deadline_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.deadline != '0) == (state_q.track == cadt_pkg::TRK_WAITING))
    else $error("deadline and waiting state disagree");

  // an accepted observe always confirms
  a_observe_confirms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !step_bad && (item_q.action == cadt_pkg::ACT_OBSERVE)
    |=> state_q.track == cadt_pkg::TRK_CONFIRMED)
    else $error("accepted observe did not confirm");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked output");

endmodule

// ----- bench/call_ack_deadline_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// call_ack_deadline_tracker_tb
// Self-checking bench: directed and random call event streams are driven
// through the valid/ready input while an in-bench tracker predicts status and
// ack state for every accepted item; results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module call_ack_deadline_tracker_tb;

  localparam logic [3:0]  ADDR_LOCAL   = {cadt_pkg::REG_LOCAL_ADDRESS, 3'b000};
  localparam logic [3:0]  ADDR_TIMEOUT = {cadt_pkg::REG_ACK_TIMEOUT_MS, 3'b000};
  localparam logic [63:0] T_MAX        = '1;
  localparam int          DRAIN_LIMIT  = 50000;

  typedef struct packed {
    logic       status;
    logic [2:0] ack_state;
  } outcome_t;

  logic            clk_i;
  logic            rst_ni  = 1'b0;
  logic            psel    = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite  = 1'b0;
  logic [3:0]      paddr   = '0;
  logic [63:0]     pwdata  = '0;
  logic [63:0]     prdata;
  logic            pready;
  logic            in_valid  = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  logic            status_o;
  logic [2:0]      ack_state_o;
  cadt_pkg::item_t cur_item  = '0;

  cadt_pkg::item_t call_events[$];
  outcome_t        expected_outcomes[$];
  int              errors = 0;
  int              queued = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;

  // tracker copy and its registers
  logic [cadt_pkg::ADDR_W-1:0] c_local   = '0;
  logic [cadt_pkg::TMO_W-1:0]  c_timeout = cadt_pkg::ACK_TIMEOUT_RESET;
  logic [2:0]                  m_track   = cadt_pkg::ACK_IDLE;
  logic [cadt_pkg::GEN_W-1:0]  m_gen     = '0;
  logic [cadt_pkg::ADDR_W-1:0] m_src     = '0;
  logic [cadt_pkg::ADDR_W-1:0] m_dst     = '0;
  logic                        m_hang    = 1'b0;
  logic [cadt_pkg::MID_W-1:0]  m_mid     = '0;
  logic [63:0]                 m_last    = '0;
  logic [63:0]                 m_deadline = '0;

  // stimulus session
  logic [63:0]                 g_now = '0;
  logic                        g_hang;
  logic [cadt_pkg::GEN_W-1:0]  g_sgen;
  logic [cadt_pkg::ADDR_W-1:0] g_peer;
  logic [1:0]                  g_state;
  logic [55:0]                 g_pay;
  logic                        need_init = 1'b1;

  call_ack_deadline_tracker u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .action_i             (cur_item.action),
    .now_ms_i             (cur_item.now_ms),
    .sess_gen_i           (cur_item.sess_gen),
    .session_peer_i       (cur_item.session_peer),
    .session_state_i      (cur_item.session_state),
    .source_addr_i        (cur_item.source_addr),
    .dest_addr_i          (cur_item.dest_addr),
    .command_generation_i (cur_item.command_generation),
    .kind_i               (cur_item.kind),
    .opcode_i             (cur_item.opcode),
    .pay_len_i            (cur_item.pay_len),
    .payload_i            (cur_item.payload),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .status_o             (status_o),
    .ack_state_o          (ack_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL call_ack_deadline_tracker");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic session_matches(input logic [cadt_pkg::GEN_W-1:0] gen,
                                           input logic [cadt_pkg::ADDR_W-1:0] src,
                                           input logic [cadt_pkg::ADDR_W-1:0] dst,
                                           input logic hang, input cadt_pkg::item_t it);
    if (gen != it.sess_gen || dst != it.session_peer || src != c_local)
      return 1'b0;
    if (!hang) return it.session_state == cadt_pkg::SS_RINGING;
    return it.session_state == cadt_pkg::SS_PREVIEW ||
           it.session_state == cadt_pkg::SS_RINGING ||
           it.session_state == cadt_pkg::SS_TALKING;
  endfunction

  function automatic logic command_valid(input cadt_pkg::item_t it);
    logic [55:0] p;
    p = it.payload;
    if (it.kind == cadt_pkg::KIND_NONE || it.command_generation == '0 ||
        it.source_addr == '0 || it.dest_addr == '0)
      return 1'b0;
    if (it.kind == cadt_pkg::KIND_ANSWER)
      return it.opcode == cadt_pkg::OP_ANSWER && it.pay_len == cadt_pkg::ANSWER_LEN &&
             p[7:0] == cadt_pkg::ANSWER_TAG && p[31:24] == 8'd0 &&
             (p[15:8] != 8'd0 || p[23:16] != 8'd0) &&
             (p[39:32] != 8'd0 || p[47:40] != 8'd0) && p[55:48] != 8'd0;
    return it.kind == cadt_pkg::KIND_HANGUP && it.opcode == cadt_pkg::OP_HANGUP &&
           it.pay_len == cadt_pkg::HANGUP_LEN;
  endfunction

  function automatic logic reply_matches(input cadt_pkg::item_t it);
    if (it.kind != cadt_pkg::REPLY_FAMILY || it.source_addr != m_dst ||
        it.dest_addr != m_src)
      return 1'b0;
    if (m_hang)
      return it.opcode == cadt_pkg::OP_HANGUP_ACK &&
             it.pay_len == cadt_pkg::HANGUP_ACK_LEN;
    return it.opcode == cadt_pkg::OP_ANSWER_ACK && it.pay_len == cadt_pkg::ANSWER_LEN &&
           it.payload[7:0] == 8'd0 && it.payload[47:8] == m_mid &&
           it.payload[55:48] != 8'd0;
  endfunction

  function automatic outcome_t step_tracker(input cadt_pkg::item_t it);
    outcome_t    res;
    logic [64:0] sum;
    res.status = 1'b0;
    case (it.action)
      cadt_pkg::ACT_INIT: begin
        m_track    = cadt_pkg::ACK_IDLE;
        m_gen      = '0;
        m_src      = '0;
        m_dst      = '0;
        m_hang     = 1'b0;
        m_mid      = '0;
        m_deadline = '0;
        m_last     = it.now_ms;
      end
      cadt_pkg::ACT_BEGIN: begin
        sum = {1'b0, it.now_ms} + {33'd0, c_timeout};
        if (m_track == cadt_pkg::ACK_WAITING || !command_valid(it) || c_timeout == '0 ||
            it.now_ms < m_last || sum[64] ||
            !session_matches(it.command_generation, it.source_addr, it.dest_addr,
                             it.kind == cadt_pkg::KIND_HANGUP, it)) begin
          res.status = 1'b1;
        end else begin
          m_gen      = it.command_generation;
          m_src      = it.source_addr;
          m_dst      = it.dest_addr;
          m_hang     = (it.kind == cadt_pkg::KIND_HANGUP);
          m_mid      = it.payload[47:8];
          m_track    = cadt_pkg::ACK_WAITING;
          m_last     = it.now_ms;
          m_deadline = sum[63:0];
        end
      end
      cadt_pkg::ACT_OBSERVE: begin
        if (m_track != cadt_pkg::ACK_WAITING || it.now_ms < m_last ||
            it.now_ms >= m_deadline ||
            !session_matches(m_gen, m_src, m_dst, m_hang, it) ||
            !reply_matches(it)) begin
          res.status = 1'b1;
        end else begin
          m_last     = it.now_ms;
          m_deadline = '0;
          m_track    = cadt_pkg::ACK_CONFIRMED;
        end
      end
      default: begin
        if (it.now_ms < m_last) begin
          res.status = 1'b1;
        end else begin
          m_last = it.now_ms;
          if (m_track == cadt_pkg::ACK_WAITING) begin
            if (!session_matches(m_gen, m_src, m_dst, m_hang, it)) begin
              m_track    = cadt_pkg::ACK_CANCELLED;
              m_deadline = '0;
            end else if (it.now_ms >= m_deadline) begin
              m_track    = cadt_pkg::ACK_EXPIRED;
              m_deadline = '0;
            end
          end
        end
      end
    endcase
    res.ack_state = m_track;
    return res;
  endfunction

  // ------------------------------------------------------- driver and monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur_item <= '0;
    end else begin
      if (in_valid && in_ready_o) expected_outcomes.push_back(step_tracker(cur_item));
      if (!in_valid || in_ready_o) begin
        if (call_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item <= call_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t result with nothing outstanding: status=%0d ack_state=%0d",
                 $time, status_o, ack_state_o);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, status_o);
          errors++;
        end
        if (ack_state_o !== want.ack_state) begin
          $display("%0t ack_state mismatch: expected %0d actual %0d",
                   $time, want.ack_state, ack_state_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cadt_pkg::item_t rand_item();
    cadt_pkg::item_t it;
    it.action             = 2'($urandom_range(0, 3));
    it.now_ms             = rand64();
    it.sess_gen           = $urandom;
    it.session_peer       = 48'(rand64());
    it.session_state      = 2'($urandom_range(0, 3));
    it.source_addr        = 48'(rand64());
    it.dest_addr          = 48'(rand64());
    it.command_generation = $urandom;
    it.kind               = 8'($urandom);
    it.opcode             = 8'($urandom);
    it.pay_len            = 8'($urandom);
    it.payload            = 56'(rand64());
    return it;
  endfunction

  function automatic cadt_pkg::item_t init_item(input logic [63:0] t);
    cadt_pkg::item_t it;
    it        = rand_item();
    it.action = cadt_pkg::ACT_INIT;
    it.now_ms = t;
    return it;
  endfunction

  function automatic cadt_pkg::item_t tick_item(input logic [63:0] t);
    cadt_pkg::item_t it;
    it               = rand_item();
    it.action        = cadt_pkg::ACT_TICK;
    it.now_ms        = t;
    it.sess_gen      = g_sgen;
    it.session_peer  = g_peer;
    it.session_state = g_state;
    return it;
  endfunction

  function automatic cadt_pkg::item_t begin_item(input logic [63:0] t);
    cadt_pkg::item_t it;
    it                    = tick_item(t);
    it.action             = cadt_pkg::ACT_BEGIN;
    it.source_addr        = c_local;
    it.dest_addr          = g_peer;
    it.command_generation = g_sgen;
    it.kind               = g_hang ? cadt_pkg::KIND_HANGUP : cadt_pkg::KIND_ANSWER;
    it.opcode             = g_hang ? cadt_pkg::OP_HANGUP : cadt_pkg::OP_ANSWER;
    it.pay_len            = g_hang ? cadt_pkg::HANGUP_LEN : cadt_pkg::ANSWER_LEN;
    if (!g_hang) it.payload = g_pay;
    return it;
  endfunction

  function automatic cadt_pkg::item_t reply_item(input logic [63:0] t);
    cadt_pkg::item_t it;
    it             = tick_item(t);
    it.action      = cadt_pkg::ACT_OBSERVE;
    it.source_addr = g_peer;
    it.dest_addr   = c_local;
    it.kind        = cadt_pkg::REPLY_FAMILY;
    it.opcode      = g_hang ? cadt_pkg::OP_HANGUP_ACK : cadt_pkg::OP_ANSWER_ACK;
    it.pay_len     = g_hang ? cadt_pkg::HANGUP_ACK_LEN : cadt_pkg::ANSWER_LEN;
    if (!g_hang) begin
      it.payload[7:0]  = 8'd0;
      it.payload[47:8] = g_pay[47:8];
      if (it.payload[55:48] == 8'd0) it.payload[48] = 1'b1;
    end
    return it;
  endfunction

  // flips bits in one field of a well-formed item
  function automatic cadt_pkg::item_t mangle(input cadt_pkg::item_t it);
    cadt_pkg::item_t m;
    m = it;
    case ($urandom_range(0, 7))
      0: m.kind               ^= 8'($urandom_range(1, 255));
      1: m.opcode             ^= 8'($urandom_range(1, 255));
      2: m.pay_len            ^= 8'($urandom_range(1, 255));
      3: m.payload            ^= 56'(1) << $urandom_range(0, 55);
      4: m.command_generation ^= 32'(1) << $urandom_range(0, 31);
      5: m.source_addr        ^= 48'(1) << $urandom_range(0, 47);
      6: m.dest_addr          ^= 48'(1) << $urandom_range(0, 47);
      default: m.session_state ^= 2'($urandom_range(1, 3));
    endcase
    return m;
  endfunction

  task automatic new_session(input logic hang, input logic [1:0] phase);
    g_hang  = hang;
    g_state = phase;
    g_sgen  = $urandom;
    if (g_sgen == '0) g_sgen = 32'd1;
    g_peer  = 48'(rand64());
    if (g_peer == '0) g_peer = 48'd1;
    g_pay          = 56'(rand64());
    g_pay[7:0]     = cadt_pkg::ANSWER_TAG;
    g_pay[31:24]   = 8'd0;
    if (g_pay[23:8] == '0) g_pay[8] = 1'b1;
    if (g_pay[47:32] == '0) g_pay[32] = 1'b1;
    if (g_pay[55:48] == '0) g_pay[48] = 1'b1;
  endtask

  task automatic queue_item(input cadt_pkg::item_t it);
    call_events.push_back(it);
    queued++;
  endtask

  task automatic run_directed();
    cadt_pkg::item_t it;
    queue_item(init_item(64'd100));
    new_session(1'b0, cadt_pkg::SS_RINGING);
    it = begin_item(64'd200); it.kind = cadt_pkg::KIND_NONE;  queue_item(it);
    it = begin_item(64'd200); it.kind = cadt_pkg::KIND_OTHER; queue_item(it);
    it = begin_item(64'd200); it.kind = 8'hFF; queue_item(it);
    queue_item(begin_item(64'd200));
    queue_item(begin_item(64'd250));     // already waiting
    queue_item(tick_item(64'd150));      // time runs backwards
    it = reply_item(64'd300); it.opcode = cadt_pkg::OP_HANGUP_ACK; queue_item(it);
    queue_item(tick_item(64'd500));
    queue_item(reply_item(64'd600));
    queue_item(reply_item(64'd650));     // no longer waiting
    queue_item(tick_item(64'd700));
    new_session(1'b1, cadt_pkg::SS_TALKING);
    queue_item(begin_item(64'd700));
    queue_item(tick_item(64'd1700));     // exactly at the deadline
    new_session(1'b1, cadt_pkg::SS_PREVIEW);
    queue_item(begin_item(64'd1800));
    it = tick_item(64'd1850); it.session_state = cadt_pkg::SS_OTHER; queue_item(it);
    new_session(1'b0, cadt_pkg::SS_RINGING);
    queue_item(begin_item(64'd1900));
    queue_item(reply_item(64'd2900));    // reply arrives at the deadline
    queue_item(tick_item(64'd2899));
    queue_item(init_item(T_MAX - 64'd1000));
    queue_item(begin_item(T_MAX - 64'd999));   // deadline would overflow
    queue_item(begin_item(T_MAX - 64'd1000));
    it = reply_item(T_MAX - 64'd1);
    it.opcode  = cadt_pkg::OP_HANGUP_ACK;
    it.pay_len = '0;
    queue_item(it);
    queue_item(tick_item(T_MAX));
    queue_item(init_item(64'd0));
  endtask

  task automatic run_sequence();
    cadt_pkg::item_t it;
    int              steps;
    logic [63:0]     dl;
    logic            hang;
    if (need_init || $urandom_range(0, 99) < 30) begin
      if ($urandom_range(0, 19) == 0) g_now = T_MAX - 64'($urandom);
      else g_now = {32'($urandom_range(0, 3)), $urandom};
      queue_item(init_item(g_now));
      need_init = 1'b0;
    end
    if ($urandom_range(0, 9) == 0) begin
      steps = $urandom_range(1, 3);
      repeat (steps) begin
        it = rand_item();
        if ($urandom_range(0, 7) != 0) it.now_ms = g_now + $urandom_range(0, 100);
        else need_init = 1'b1;
        queue_item(it);
      end
      return;
    end
    hang = 1'($urandom_range(0, 1));
    new_session(hang, hang ? 2'($urandom_range(1, 3)) : cadt_pkg::SS_RINGING);
    g_now += $urandom_range(0, 50);
    it = begin_item(g_now);
    if ($urandom_range(0, 5) == 0) it = mangle(it);
    queue_item(it);
    dl = g_now + c_timeout;
    steps = $urandom_range(1, 5);
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          g_now += $urandom_range(0, c_timeout / 4);
          queue_item(tick_item(g_now));
        end
        3, 4, 5: begin
          g_now += $urandom_range(0, c_timeout / 4);
          it = reply_item(g_now);
          if ($urandom_range(0, 3) == 0) it = mangle(it);
          queue_item(it);
        end
        6: begin
          // session moved on under the command
          g_now += $urandom_range(0, 20);
          it = tick_item(g_now);
          if ($urandom_range(0, 1) == 0) it.session_state = cadt_pkg::SS_OTHER;
          else it.sess_gen ^= 32'(1) << $urandom_range(0, 31);
          queue_item(it);
        end
        7: begin
          if (dl >= g_now) g_now = dl - $urandom_range(0, 1);
          queue_item($urandom_range(0, 1) ? tick_item(g_now) : reply_item(g_now));
        end
        8: begin
          dl = g_now - $urandom_range(1, 100);
          queue_item($urandom_range(0, 1) ? tick_item(dl) : reply_item(dl));
          dl = g_now + c_timeout;
        end
        default: begin
          g_now += $urandom_range(0, 10);
          queue_item(begin_item(g_now));
        end
      endcase
    end
  endtask

  task automatic fill(input int n);
    int target;
    target = queued + n;
    while (queued < target) run_sequence();
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    do begin
      @(negedge clk_i);
      n++;
    end while (!(call_events.size() == 0 && !in_valid && expected_outcomes.size() == 0)
               && n < DRAIN_LIMIT);
    if (expected_outcomes.size() != 0 || call_events.size() != 0) begin
      $display("%0t results still outstanding: expected %0d actual 0",
               $time, expected_outcomes.size());
      errors++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TIMEOUT) c_timeout = data[cadt_pkg::TMO_W-1:0];
    else c_local = data[cadt_pkg::ADDR_W-1:0];
  endtask

  task automatic configure(input logic [cadt_pkg::ADDR_W-1:0] own,
                           input logic [cadt_pkg::TMO_W-1:0] tmo);
    write_reg(ADDR_LOCAL, {16'($urandom), own});
    write_reg(ADDR_TIMEOUT, {$urandom, tmo});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(48'h0123_4567_89AB, 32'd1000);
    run_directed();
    wait_drain();

    configure(48'(rand64()), 32'($urandom_range(1, 5000)));
    fill(125);
    wait_drain();      // sender holds off until everything is back
    fill(125);
    wait_drain();

    configure('1, '1);
    send_idle_pct <= 78;
    fill(200);
    wait_drain();

    configure(48'(rand64()), 32'd1);
    send_idle_pct <= 0;
    stall_pct     <= 78;
    fill(200);
    wait_drain();

    configure('0, '0);
    send_idle_pct <= 15;
    stall_pct     <= 15;
    fill(50);
    wait_drain();

    configure(48'(rand64()), $urandom);
    fill(250);
    wait_drain();

    if (errors == 0) begin
      $display("PASS call_ack_deadline_tracker");
    end else begin
      $display("FAIL call_ack_deadline_tracker");
    end
    $finish;
  end

endmodule
